[sv/gmps_pkg.sv]
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared types and constants for the grid maze path search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmps_pkg;

    // Item field widths
    localparam int FUNC_W = 2;
    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_SOLVE = 2'd1,
        FN_READ  = 2'd2
    } func_t;

    // Direction codes, tried in this order; DIR_END means all four are done
    localparam int DIR_W = 3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_END   = 3'd4;

    // Search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRY,
        ST_CHECK,
        ST_POP
    } srch_st_t;

    // Search engine requests toward the cell memories and the result logic
    typedef struct packed {
        logic maze_rd;    // read maze cell at cell_addr
        logic mark_rd;    // read path mark at cell_addr
        logic mark_we;    // write path mark at cell_addr
        logic mark_wbit;  // value to write
        logic fin;        // solve item finished this cycle
        logic hit;        // goal reached (valid with fin)
    } srch_ctl_t;

endpackage

`default_nettype wire

[sv/grid_maze_path_search_top.sv]
// ----------------------------------------------------------------------------
// grid_maze_path_search_top
// Maze cell store, path mark store and depth-first path search.
//
//  channel  ports                          handshake
//  -------  -----------------------------  -------------------------------
//  item     func, row, col, cell_open      taken when start && !busy
//  result   found, path_bit                one cycle, marked by done
//
//  Write, read and unused items: one per cycle, result one cycle after.
//  Solve: busy for the search; each try is its own state, each cell check
//  waits on the maze/mark memory read, and each retreat above the last frame
//  adds a pop state for the stack memory read. Result is registered at the end.
//  Reset clears maze and marks at once through per-cell valid bits.
//  The receiver cannot stall; done pulses once per item.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_path_search_top #(
    parameter int SIDE = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gmps_pkg::FUNC_W-1:0] func,
    input  logic [gmps_pkg::ROW_W-1:0]  row,
    input  logic [gmps_pkg::COL_W-1:0]  col,
    input  logic                        cell_open,
    output logic                        done,
    output logic                        found,
    output logic                        path_bit
);

    import gmps_pkg::*;

    localparam int RW = $clog2(SIDE);
    localparam int AW = 2 * RW;
    localparam int NC = 1 << AW;

    logic            accept, in_ok, is_wr, is_solve, is_rd;
    logic [RW-1:0]   in_r, in_c;
    logic [AW-1:0]   in_addr, srch_addr, mark_raddr;
    srch_ctl_t       ctl;
    logic            srch_busy;

    logic            maze_we, mark_re;
    logic            maze_q, mark_q;
    logic            maze_bit, mark_bit;

    logic [NC-1:0]   maze_vld_reg, maze_vld_next;
    logic [NC-1:0]   mark_vld_reg, mark_vld_next;
    logic            maze_vq_reg, maze_vq_next;
    logic            mark_vq_reg, mark_vq_next;
    logic            done_reg, done_next;
    logic            path_pend_reg, path_pend_next;
    logic            last_found_reg, last_found_next;

    // Item decode
    assign accept   = start && !srch_busy;
    assign in_ok    = (32'(row) < SIDE) && (32'(col) < SIDE);
    assign in_r     = RW'(row);
    assign in_c     = RW'(col);
    assign in_addr  = {in_r, in_c};
    assign is_wr    = accept && (func == FN_WRITE);
    assign is_solve = accept && (func == FN_SOLVE);
    assign is_rd    = accept && (func == FN_READ);

    gmps_search #(
        .SIDE (SIDE)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (is_solve),
        .go_ok     (in_ok),
        .go_row    (in_r),
        .go_col    (in_c),
        .maze_bit  (maze_bit),
        .mark_bit  (mark_bit),
        .cell_addr (srch_addr),
        .ctl       (ctl),
        .busy      (srch_busy)
    );

    // Maze cells: written by items, read by the search
    assign maze_we = is_wr && in_ok;

    gmps_ram #(
        .WIDTH (1),
        .DEPTH (NC)
    ) u_maze (
        .clk   (clk),
        .we    (maze_we),
        .waddr (in_addr),
        .wdata (cell_open),
        .re    (ctl.maze_rd),
        .raddr (srch_addr),
        .rdata (maze_q)
    );

    // Path marks: written by the search, read by it and by read items
    assign mark_re    = ctl.mark_rd || is_rd;
    assign mark_raddr = is_rd ? in_addr : srch_addr;

    gmps_ram #(
        .WIDTH (1),
        .DEPTH (NC)
    ) u_mark (
        .clk   (clk),
        .we    (ctl.mark_we),
        .waddr (srch_addr),
        .wdata (ctl.mark_wbit),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_q)
    );

    // A never-written entry reads as zero
    assign maze_bit = maze_vq_reg && maze_q;
    assign mark_bit = mark_vq_reg && mark_q;

    // Valid bits and their sample at read time
    always_comb
    begin
        maze_vld_next = maze_vld_reg;
        mark_vld_next = mark_vld_reg;
        maze_vq_next  = maze_vq_reg;
        mark_vq_next  = mark_vq_reg;
        if (maze_we)
        begin
            maze_vld_next[in_addr] = 1'b1;
        end
        if (is_solve)
        begin
            mark_vld_next = '0;
        end
        else if (ctl.mark_we)
        begin
            mark_vld_next[srch_addr] = 1'b1;
        end
        if (ctl.maze_rd)
        begin
            maze_vq_next = maze_vld_reg[srch_addr];
        end
        if (mark_re)
        begin
            // solve start reads the start cell after the marks are wiped
            mark_vq_next = !is_solve && mark_vld_reg[mark_raddr];
        end
    end

    // Result
    always_comb
    begin
        done_next       = (accept && (func != FN_SOLVE)) || ctl.fin;
        path_pend_next  = is_rd && in_ok;
        last_found_next = ctl.fin ? ctl.hit : last_found_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maze_vld_reg   <= '0;
            mark_vld_reg   <= '0;
            maze_vq_reg    <= 1'b0;
            mark_vq_reg    <= 1'b0;
            done_reg       <= 1'b0;
            path_pend_reg  <= 1'b0;
            last_found_reg <= 1'b0;
        end
        else
        begin
            maze_vld_reg   <= maze_vld_next;
            mark_vld_reg   <= mark_vld_next;
            maze_vq_reg    <= maze_vq_next;
            mark_vq_reg    <= mark_vq_next;
            done_reg       <= done_next;
            path_pend_reg  <= path_pend_next;
            last_found_reg <= last_found_next;
        end
    end

    assign busy     = srch_busy;
    assign done     = done_reg;
    assign found    = last_found_reg;
    assign path_bit = path_pend_reg && mark_bit;

endmodule

`default_nettype wire

[sv/gmps_ram.sv]
// ----------------------------------------------------------------------------
// gmps_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gmps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/gmps_search.sv]
// ----------------------------------------------------------------------------
// gmps_search
// Depth-first backtracking sequencer. The top frame lives in registers, the
// frames below it in a stack RAM. Maze and mark reads go out in the cycle
// before the check that uses them.
// ----------------------------------------------------------------------------
`default_nettype none

module gmps_search #(
    parameter int SIDE = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic                          go_ok,
    input  logic [$clog2(SIDE)-1:0]       go_row,
    input  logic [$clog2(SIDE)-1:0]       go_col,
    input  logic                          maze_bit,
    input  logic                          mark_bit,
    output logic [2*$clog2(SIDE)-1:0]     cell_addr,
    output gmps_pkg::srch_ctl_t           ctl,
    output logic                          busy
);

    import gmps_pkg::*;

    localparam int RW    = $clog2(SIDE);
    localparam int AW    = 2 * RW;
    localparam int CELLS = SIDE * SIDE;
    localparam int SAW   = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam int FW    = AW + DIR_W;
    localparam logic [RW-1:0] LAST      = RW'(SIDE - 1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(CELLS);

    srch_st_t         st_reg, st_next;
    logic [RW-1:0]    top_r_reg, top_r_next;
    logic [RW-1:0]    top_c_reg, top_c_next;
    logic [DIR_W-1:0] top_dir_reg, top_dir_next;
    logic [RW-1:0]    nb_r_reg, nb_r_next;
    logic [RW-1:0]    nb_c_reg, nb_c_next;
    logic [DW-1:0]    depth_reg, depth_next;
    logic [DW-1:0]    depth_m1, depth_m2;

    logic [RW-1:0]    try_r, try_c;
    logic             try_ok;
    logic             dir_end, at_root, last_frame, is_goal, can_push;

    logic             stk_we, stk_re;
    logic [FW-1:0]    stk_wdata, stk_rdata;

    // Frames below the top
    gmps_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_m1[SAW-1:0]),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (depth_m2[SAW-1:0]),
        .rdata (stk_rdata)
    );

    // Neighbor of the top cell in its next direction
    always_comb
    begin
        try_r  = top_r_reg;
        try_c  = top_c_reg;
        try_ok = 1'b0;
        case (top_dir_reg)
            DIR_DOWN:
            begin
                try_r  = top_r_reg + RW'(1);
                try_ok = (top_r_reg != LAST);
            end
            DIR_RIGHT:
            begin
                try_c  = top_c_reg + RW'(1);
                try_ok = (top_c_reg != LAST);
            end
            DIR_UP:
            begin
                try_r  = top_r_reg - RW'(1);
                try_ok = (top_r_reg != '0);
            end
            DIR_LEFT:
            begin
                try_c  = top_c_reg - RW'(1);
                try_ok = (top_c_reg != '0);
            end
            default:
            begin
                try_ok = 1'b0;
            end
        endcase
    end

    assign depth_m1   = depth_reg - DW'(1);
    assign depth_m2   = depth_reg - DW'(2);
    assign dir_end    = (top_dir_reg >= DIR_END);
    assign at_root    = (depth_reg == '0);
    assign last_frame = (depth_reg == DW'(1));
    assign is_goal    = (nb_r_reg == LAST) && (nb_c_reg == LAST);
    assign can_push   = maze_bit && !mark_bit && (depth_reg < DEPTH_MAX);
    assign stk_wdata  = {top_r_reg, top_c_reg, top_dir_reg};
    assign busy       = (st_reg != ST_IDLE);

    // Next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (go && go_ok)
                begin
                    st_next = ST_CHECK;
                end
            end
            ST_TRY:
            begin
                if (dir_end)
                begin
                    st_next = last_frame ? ST_IDLE : ST_POP;
                end
                else if (try_ok)
                begin
                    st_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (is_goal)
                begin
                    st_next = (maze_bit || at_root) ? ST_IDLE : ST_TRY;
                end
                else
                begin
                    st_next = (can_push || !at_root) ? ST_TRY : ST_IDLE;
                end
            end
            ST_POP:
            begin
                st_next = ST_TRY;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and frame updates
    always_comb
    begin
        ctl          = '0;
        cell_addr    = {nb_r_reg, nb_c_reg};
        top_r_next   = top_r_reg;
        top_c_next   = top_c_reg;
        top_dir_next = top_dir_reg;
        nb_r_next    = nb_r_reg;
        nb_c_next    = nb_c_reg;
        depth_next   = depth_reg;
        stk_we       = 1'b0;
        stk_re       = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                cell_addr = {go_row, go_col};
                if (go)
                begin
                    depth_next = '0;
                    if (go_ok)
                    begin
                        ctl.maze_rd = 1'b1;
                        ctl.mark_rd = 1'b1;
                        nb_r_next   = go_row;
                        nb_c_next   = go_col;
                    end
                    else
                    begin
                        ctl.fin = 1'b1;
                    end
                end
            end
            ST_TRY:
            begin
                if (dir_end)
                begin
                    // retreat: unmark and drop the top frame
                    cell_addr     = {top_r_reg, top_c_reg};
                    ctl.mark_we   = 1'b1;
                    ctl.mark_wbit = 1'b0;
                    depth_next    = depth_m1;
                    if (last_frame)
                    begin
                        ctl.fin = 1'b1;
                    end
                    else
                    begin
                        stk_re = 1'b1;
                    end
                end
                else
                begin
                    top_dir_next = top_dir_reg + DIR_W'(1);
                    if (try_ok)
                    begin
                        cell_addr   = {try_r, try_c};
                        ctl.maze_rd = 1'b1;
                        ctl.mark_rd = 1'b1;
                        nb_r_next   = try_r;
                        nb_c_next   = try_c;
                    end
                end
            end
            ST_CHECK:
            begin
                if (is_goal)
                begin
                    if (maze_bit)
                    begin
                        ctl.mark_we   = 1'b1;
                        ctl.mark_wbit = 1'b1;
                        ctl.fin       = 1'b1;
                        ctl.hit       = 1'b1;
                    end
                    else if (at_root)
                    begin
                        ctl.fin = 1'b1;
                    end
                end
                else if (can_push)
                begin
                    // advance: old top goes to the stack RAM
                    ctl.mark_we   = 1'b1;
                    ctl.mark_wbit = 1'b1;
                    stk_we        = !at_root;
                    top_r_next    = nb_r_reg;
                    top_c_next    = nb_c_reg;
                    top_dir_next  = DIR_DOWN;
                    depth_next    = depth_reg + DW'(1);
                end
                else if (at_root)
                begin
                    ctl.fin = 1'b1;
                end
            end
            ST_POP:
            begin
                {top_r_next, top_c_next, top_dir_next} = stk_rdata;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            depth_reg <= '0;
        end
        else
        begin
            st_reg    <= st_next;
            depth_reg <= depth_next;
        end
    end

    // Frame payload
    always_ff @(posedge clk)
    begin
        top_r_reg   <= top_r_next;
        top_c_reg   <= top_c_next;
        top_dir_reg <= top_dir_next;
        nb_r_reg    <= nb_r_next;
        nb_c_reg    <= nb_c_next;
    end

    // Checks
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("stack depth beyond grid size");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin |=> (st_reg == ST_IDLE))
        else $error("search did not return to idle after finishing");

    a_pop_try: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_POP) |=> (st_reg == ST_TRY))
        else $error("restored frame not followed by a try");

    a_check_read: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_CHECK) |-> $past(ctl.maze_rd && ctl.mark_rd))
        else $error("cell check without a read one cycle before");

endmodule

`default_nettype wire
